FILE: hdl/pte4_pkg.sv
// Package with the constants, types and helper functions of the page table engine.
`default_nettype none
package pte4_pkg;

  localparam int TABLE_FRAMES = 16;
  localparam int FRAME_IDX_W  = $clog2(TABLE_FRAMES);
  localparam int ALLOC_W      = $clog2(TABLE_FRAMES + 1);
  localparam int ENTRY_IDX_W  = 9;
  localparam int STORE_DEPTH  = TABLE_FRAMES * (1 << ENTRY_IDX_W);
  localparam int STORE_ADDR_W = FRAME_IDX_W + ENTRY_IDX_W;
  localparam int ENTRY_W      = 64;

  localparam logic [ENTRY_W-1:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [11:0]        LINK_BITS = 12'h007;

  typedef enum logic [1:0] {
    CMD_MAP     = 2'd0,
    CMD_UNMAP   = 2'd1,
    CMD_PROTECT = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_TABLES  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

  function automatic logic [ENTRY_W-1:0] pack_flags(input logic [23:0] f);
    return {f[23:12], 40'b0, f[11:0]};
  endfunction

  function automatic logic [23:0] unpack_flags(input logic [ENTRY_W-1:0] e);
    return {e[63:52], e[11:0]};
  endfunction

  function automatic logic [ENTRY_IDX_W-1:0] level_index(input logic [35:0] vp,
                                                         input logic [1:0] lvl);
    logic [ENTRY_IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = vp[35:27];
      2'd1:    idx = vp[26:18];
      2'd2:    idx = vp[17:9];
      default: idx = vp[8:0];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pte4_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module pte4_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hdl/four_level_page_table_engine.sv
// Top level of the four-level page table engine: walk sequencer around the table store.
`default_nettype none
// After reset the engine holds busy high for a clearing pass over all TABLE_FRAMES * 512
// entries (8192 at the default size) that zeroes the table store. After that a request
// is taken when start is high and busy is low, and it goes through these steps: the
// transfer cycle, which reads the root entry, three steps that each check an upper level
// entry and read the next level, one step that checks the leaf and writes it unless the
// command is a lookup, and the return to idle, during which done pulses with the result.
// A new request may be transferred in that same cycle. A walk that meets a missing level,
// or a map that runs out of table frames, ends early. The single-port table store allows
// one access per cycle, so each step reads or writes one entry. A level created by map is
// known to be empty, so its link write replaces the read of that level. Results cannot be
// stalled: status, frame_out and flags_out are valid only in the cycle in which done
// is high.
module four_level_page_table_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [35:0] virt_page,
  input  wire logic [39:0] phys_frame,
  input  wire logic [23:0] flags,
  output logic             done,
  output logic [1:0]       status,
  output logic [39:0]      frame_out,
  output logic [23:0]      flags_out
);

  pte4_pkg::state_t  state, state_next;
  pte4_pkg::cmd_t    cmd_r;
  logic [35:0]       vp_r;
  logic [39:0]       pf_r;
  logic [23:0]       fl_r;

  logic [1:0]                          lvl, lvl_next;
  logic [pte4_pkg::FRAME_IDX_W-1:0]    table_idx, table_idx_next;
  logic                                fresh, fresh_next;
  logic [pte4_pkg::ALLOC_W-1:0]        next_free, next_free_next;
  logic [pte4_pkg::STORE_ADDR_W-1:0]   clr_cnt;

  logic                                done_next;
  pte4_pkg::status_t                   status_r, status_next;
  logic [39:0]                         frame_r, frame_next;
  logic [23:0]                         flags_r, flags_next;

  logic                                mem_we;
  logic [pte4_pkg::STORE_ADDR_W-1:0]   mem_addr;
  logic [pte4_pkg::ENTRY_W-1:0]        mem_wdata;
  logic [pte4_pkg::ENTRY_W-1:0]        mem_rdata;

  logic [pte4_pkg::ENTRY_W-1:0]        entry;
  logic [39:0]                         link_frame;
  logic                                link_bad;
  logic                                accept;

  pte4_ram #(
    .WIDTH (pte4_pkg::ENTRY_W),
    .DEPTH (pte4_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy      = (state != pte4_pkg::S_IDLE);
  assign accept    = start && (state == pte4_pkg::S_IDLE);
  assign status    = status_r;
  assign frame_out = frame_r;
  assign flags_out = flags_r;

  assign entry      = fresh ? '0 : mem_rdata;
  assign link_frame = entry[51:12];
  assign link_bad   = (link_frame >= 40'(pte4_pkg::TABLE_FRAMES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pte4_pkg::S_CLEAR;
      clr_cnt   <= '0;
      next_free <= pte4_pkg::ALLOC_W'(1);
      done      <= 1'b0;
      lvl       <= '0;
      table_idx <= '0;
      fresh     <= 1'b0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      done      <= done_next;
      lvl       <= lvl_next;
      table_idx <= table_idx_next;
      fresh     <= fresh_next;
      if (state == pte4_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= pte4_pkg::cmd_t'(cmd);
      vp_r  <= virt_page;
      pf_r  <= phys_frame;
      fl_r  <= flags;
    end
    status_r <= status_next;
    frame_r  <= frame_next;
    flags_r  <= flags_next;
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    table_idx_next = table_idx;
    fresh_next     = fresh;
    next_free_next = next_free;
    done_next      = 1'b0;
    status_next    = pte4_pkg::ST_DONE;
    frame_next     = '0;
    flags_next     = '0;
    mem_we         = 1'b0;
    mem_addr       = {table_idx, pte4_pkg::level_index(vp_r, lvl)};
    mem_wdata      = '0;

    case (state)
      pte4_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (clr_cnt == pte4_pkg::STORE_ADDR_W'(pte4_pkg::STORE_DEPTH - 1)) begin
          state_next = pte4_pkg::S_IDLE;
        end
      end

      pte4_pkg::S_IDLE: begin
        mem_addr = {{pte4_pkg::FRAME_IDX_W{1'b0}}, pte4_pkg::level_index(virt_page, 2'd0)};
        if (start) begin
          state_next     = pte4_pkg::S_WALK;
          lvl_next       = 2'd0;
          table_idx_next = '0;
          fresh_next     = 1'b0;
        end
      end

      pte4_pkg::S_WALK: begin
        if (lvl != 2'd3) begin
          if (entry[0]) begin
            if (link_bad) begin
              done_next   = 1'b1;
              status_next = pte4_pkg::ST_NOT_MAPPED;
              state_next  = pte4_pkg::S_IDLE;
            end else begin
              table_idx_next = link_frame[pte4_pkg::FRAME_IDX_W-1:0];
              lvl_next       = lvl + 2'd1;
              mem_addr       = {link_frame[pte4_pkg::FRAME_IDX_W-1:0],
                                pte4_pkg::level_index(vp_r, lvl + 2'd1)};
            end
          end else if (cmd_r != pte4_pkg::CMD_MAP) begin
            done_next   = 1'b1;
            status_next = pte4_pkg::ST_NOT_MAPPED;
            state_next  = pte4_pkg::S_IDLE;
          end else if (next_free >= pte4_pkg::ALLOC_W'(pte4_pkg::TABLE_FRAMES)) begin
            done_next   = 1'b1;
            status_next = pte4_pkg::ST_NO_TABLES;
            state_next  = pte4_pkg::S_IDLE;
          end else begin
            mem_we         = 1'b1;
            mem_wdata      = {12'b0, 40'(next_free), pte4_pkg::LINK_BITS};
            table_idx_next = next_free[pte4_pkg::FRAME_IDX_W-1:0];
            fresh_next     = 1'b1;
            lvl_next       = lvl + 2'd1;
            next_free_next = next_free + 1'b1;
          end
        end else begin
          done_next  = 1'b1;
          state_next = pte4_pkg::S_IDLE;
          if (cmd_r == pte4_pkg::CMD_MAP) begin
            mem_we    = 1'b1;
            mem_wdata = {12'b0, pf_r, 12'b0} | pte4_pkg::pack_flags(fl_r);
          end else if (!entry[0]) begin
            status_next = pte4_pkg::ST_NOT_MAPPED;
          end else begin
            case (cmd_r)
              pte4_pkg::CMD_UNMAP: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
              end
              pte4_pkg::CMD_PROTECT: begin
                mem_we    = 1'b1;
                mem_wdata = (entry & pte4_pkg::ADDR_MASK) | pte4_pkg::pack_flags(fl_r);
              end
              default: begin
                frame_next = entry[51:12];
                flags_next = pte4_pkg::unpack_flags(entry);
              end
            endcase
          end
        end
      end

      default: begin
        state_next = pte4_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the four-level page table engine: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pte4_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_ITEMS   = 1550;

  typedef struct packed {
    status_t     status;
    logic [39:0] frame;
    logic [23:0] flags;
  } walk_result_t;

  class walk_scoreboard;
    bit [63:0]    table_copy [STORE_DEPTH];
    int unsigned  next_table;
    walk_result_t pending [$];
    int           errors;

    function void clear_tables();
      foreach (table_copy[i]) table_copy[i] = '0;
      next_table = 1;
      errors = 0;
      pending.delete();
    endfunction

    function status_t find_leaf(logic [35:0] vp, bit create, output int unsigned slot);
      int unsigned tbl;
      int unsigned pos;
      logic [63:0] link;
      logic [8:0]  idx;
      tbl = 0;
      slot = 0;
      for (int lvl = 0; lvl < 3; lvl++) begin
        idx = vp[35 - 9 * lvl -: 9];
        pos = tbl * 512 + idx;
        link = table_copy[pos];
        if (!link[0]) begin
          if (!create) return ST_NOT_MAPPED;
          if (next_table >= TABLE_FRAMES) return ST_NO_TABLES;
          link = {12'b0, 40'(next_table), LINK_BITS};
          next_table++;
          table_copy[pos] = link;
        end
        if (link[51:12] >= TABLE_FRAMES) return ST_NOT_MAPPED;
        tbl = 32'(link[51:12]);
      end
      slot = tbl * 512 + vp[8:0];
      return ST_DONE;
    endfunction

    function void note_request(cmd_t c, logic [35:0] vp, logic [39:0] pf, logic [23:0] fl);
      walk_result_t res;
      int unsigned  slot;
      logic [63:0]  leaf;
      res.frame = '0;
      res.flags = '0;
      if (c == CMD_MAP) begin
        res.status = find_leaf(vp, 1'b1, slot);
        if (res.status == ST_DONE) table_copy[slot] = {fl[23:12], pf, fl[11:0]};
      end else begin
        res.status = find_leaf(vp, 1'b0, slot);
        if (res.status == ST_DONE && !table_copy[slot][0]) res.status = ST_NOT_MAPPED;
        if (res.status == ST_DONE) begin
          leaf = table_copy[slot];
          case (c)
            CMD_UNMAP: begin
              table_copy[slot] = '0;
            end
            CMD_PROTECT: begin
              table_copy[slot] = {fl[23:12], leaf[51:12], fl[11:0]};
            end
            default: begin
              res.frame = leaf[51:12];
              res.flags = {leaf[63:52], leaf[11:0]};
            end
          endcase
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [39:0] fr, logic [23:0] fl);
      walk_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: status %0d frame %h flags %h",
                 $time, st, fr, fl);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (fr !== want.frame) begin
        $display("%0t: frame_out expected %h actual %h", $time, want.frame, fr);
        errors++;
      end
      if (fl !== want.flags) begin
        $display("%0t: flags_out expected %h actual %h", $time, want.flags, fl);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = '0;
  logic [35:0] virt_page = '0;
  logic [39:0] phys_frame = '0;
  logic [23:0] flags = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [39:0] frame_out;
  logic [23:0] flags_out;

  walk_scoreboard board;
  int            quiet_cycles = 0;
  logic [26:0]   prefix_pool [8];
  logic [8:0]    leaf_pool [8];

  four_level_page_table_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .virt_page  (virt_page),
    .phys_frame (phys_frame),
    .flags      (flags),
    .done       (done),
    .status     (status),
    .frame_out  (frame_out),
    .flags_out  (flags_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (done && !rst) board.check_result(status, frame_out, flags_out);
    if ((start && !busy && !rst) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [39:0] rand_frame();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[39:0];
  endfunction

  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(cmd_t c, logic [35:0] vp, logic [39:0] pf, logic [23:0] fl);
    start <= 1'b1;
    cmd <= c;
    virt_page <= vp;
    phys_frame <= pf;
    flags <= fl;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(c, vp, pf, fl);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int          r;
    cmd_t        c;
    logic [35:0] vp;
    logic [23:0] fl;
    logic [63:0] w;
    r = $urandom_range(0, 99);
    if (r < 35) c = CMD_MAP;
    else if (r < 50) c = CMD_UNMAP;
    else if (r < 70) c = CMD_PROTECT;
    else c = CMD_LOOKUP;
    fl = 24'($urandom());
    if ($urandom_range(0, 99) < 12) begin
      w = {$urandom(), $urandom()};
      vp = w[35:0];
    end else begin
      vp[35:9] = prefix_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 3) == 0) vp[8:0] = 9'($urandom());
      else vp[8:0] = leaf_pool[$urandom_range(0, 7)];
      fl[0] = ($urandom_range(0, 9) != 0);
    end
    send_request(c, vp, rand_frame(), fl);
  endtask

  initial begin
    logic [8:0] qv [4];
    logic [8:0] rv [8];
    logic [35:0] vp;
    bit         no_idle;
    board = new;
    board.clear_tables();
    qv[0] = 9'h000;
    qv[1] = 9'($urandom());
    qv[2] = 9'($urandom());
    qv[3] = 9'h1FF;
    for (int i = 0; i < 8; i++) begin
      rv[i] = 9'($urandom());
      leaf_pool[i] = 9'($urandom());
    end
    rv[0] = 9'h000;
    rv[7] = 9'h1FF;
    leaf_pool[0] = 9'h000;
    leaf_pool[7] = 9'h1FF;
    for (int i = 0; i < 8; i++) begin
      prefix_pool[i] = {(i >= 4) ? 9'h1FF : 9'h000, qv[i >> 1], rv[i]};
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_LOOKUP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_UNMAP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_PROTECT, '1, '1, '1);
    hold_off(pick_gap(0));
    send_request(CMD_MAP, '0, '1, '1);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_PROTECT, '0, '1, 24'hABC001);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '0, '1, '1);
    hold_off(pick_gap(0));
    send_request(CMD_MAP, '1, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '1, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_UNMAP, '1, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_PROTECT, '1, '0, '1);
    hold_off(pick_gap(0));
    send_request(CMD_MAP, '0, 40'h55_5555_5555, 24'hFFFFFF);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_PROTECT, '0, '0, 24'hFFFFFE);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_MAP, '0, 40'hAA_AAAA_AAAA, 24'h000001);
    hold_off(pick_gap(0));
    send_request(CMD_UNMAP, '0, '0, '0);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, '0, '0, '0);
    hold_off(pick_gap(0));
    for (int i = 1; i < 7; i++) begin
      send_request(CMD_MAP, {prefix_pool[i], leaf_pool[i]}, rand_frame(),
                   24'($urandom()) | 24'h000001);
      hold_off(pick_gap(0));
    end
    send_request(CMD_MAP, '1, rand_frame(), 24'h000001);
    hold_off(pick_gap(0));
    vp = {9'h0AA, 27'($urandom())};
    send_request(CMD_MAP, vp, rand_frame(), 24'h000007);
    hold_off(pick_gap(0));
    send_request(CMD_MAP, {9'h155, 27'($urandom())}, rand_frame(), 24'h000007);
    hold_off(pick_gap(0));
    send_request(CMD_LOOKUP, vp, '0, '0);
    hold_off(pick_gap(0));

    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random_item();
      hold_off(pick_gap(no_idle));
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
